[sv/dpp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the station-keeping PID block.
// Used by dpp_mul and dynamic_positioning_pid; no dependencies.
package dpp_pkg;

    // loop limits and table size
    localparam int INTEG_LIMIT = 8192;
    localparam int FULL_Q14    = 16384;
    localparam int TRIG_DEPTH  = 256;
    localparam int TRIG_IDX_W  = $clog2(TRIG_DEPTH);
    localparam int TWO_PI_Q16  = 411775;

    // shared multiplier: signed 64-bit multiplicand, signed 25-bit multiplier
    localparam int PROD_W    = 64;
    localparam int MUL_B_W   = 25;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // item kinds
    localparam logic [1:0] KIND_ENGAGE  = 2'd0;
    localparam logic [1:0] KIND_UPDATE  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef logic signed [15:0] trig_tab_t [TRIG_DEPTH];

    // Q14 quarter-wave sine polynomial, evaluated at elaboration only
    function automatic logic signed [15:0] isin_q14(int p);
        int quad;
        int z;
        int z2;
        int t;
        int s;
        p    = p & 16'hFFFF;
        quad = p >> 14;
        z    = p & 16'h3FFF;
        if ((quad & 1) != 0) z = 16384 - z;
        z2 = (z * z) >> 14;
        t  = (1160 * z2) >> 14;
        t  = 10512 - t;
        t  = (t * z2) >> 14;
        t  = 25736 - t;
        s  = (t * z) >> 14;
        if ((quad & 2) != 0) s = -s;
        return 16'(s);
    endfunction

    function automatic trig_tab_t build_trig_tab();
        trig_tab_t tab;
        for (int i = 0; i < TRIG_DEPTH; i++) begin
            tab[i] = isin_q14((i * 65536) / TRIG_DEPTH);
        end
        return tab;
    endfunction

    localparam trig_tab_t TRIG_TAB = build_trig_tab();

    // round half up of x / 2^n
    function automatic logic signed [PROD_W-1:0] rnd_shift(logic signed [PROD_W-1:0] x,
                                                           int n);
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(64'sd1 <<< (n - 1));
        return (x + half) >>> n;
    endfunction

    function automatic logic signed [31:0] clamp_s32(logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sh7FFF_FFFF);
        lo = -hi - PROD_W'(64'sd1);
        if (x > hi) return 32'sh7FFF_FFFF;
        if (x < lo) return 32'sh8000_0000;
        return 32'(x);
    endfunction

    function automatic logic signed [15:0] clamp_lim(logic signed [PROD_W-1:0] x, int lim);
        logic signed [PROD_W-1:0] hi;
        hi = PROD_W'(lim);
        if (x > hi) return 16'(lim);
        if (x < -hi) return 16'(-lim);
        return 16'(x);
    endfunction

endpackage

[sv/dpp_mul.sv]
`timescale 1ns / 1ps
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// Depends on dpp_pkg for operand widths.
module dpp_mul import dpp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_B_W - 1);

    logic                      run_reg;
    logic                      done_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic signed [PROD_W-1:0]  a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic signed [PROD_W-1:0]  acc_reg;

    // sequence the bit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // add or, for the sign bit, subtract the shifted multiplicand
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (run_reg) begin
            if (b_reg[0]) begin
                acc_reg <= (cnt_reg == CNT_LAST) ? acc_reg - a_reg : acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >>> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

[sv/dynamic_positioning_pid.sv]
`timescale 1ns / 1ps
// Station-keeping PID: three loops, body-frame rotation, Q14 commands.
// Engage, release and ignored items pass through the decide and output states to a result.
// An update runs 19 products through one bit-serial multiplier, each product passing
// through the issue, wait and write-back states before the result is formed.
// One item at a time; the next beat is taken while a result waits on the output.
// aresetn (synchronous, active low) loads register defaults and clears all loop state.
module dynamic_positioning_pid import dpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // pos_north[31:0], pos_east[63:32], heading[79:64],
                                   // pos_valid[80], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // forward_cmd[15:0], lateral_cmd[31:16], yaw_cmd[47:32],
                                   // holding[48], zero fill
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // controller states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_WB     = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // product steps of an update
    localparam logic [4:0] STEP_DB_SQ    = 5'd0;
    localparam logic [4:0] STEP_N_SQ     = 5'd1;
    localparam logic [4:0] STEP_E_SQ     = 5'd2;
    localparam logic [4:0] STEP_N_KI     = 5'd3;
    localparam logic [4:0] STEP_N_KP     = 5'd4;
    localparam logic [4:0] STEP_N_KD     = 5'd5;
    localparam logic [4:0] STEP_E_KI     = 5'd6;
    localparam logic [4:0] STEP_E_KP     = 5'd7;
    localparam logic [4:0] STEP_E_KD     = 5'd8;
    localparam logic [4:0] STEP_Y_KI     = 5'd9;
    localparam logic [4:0] STEP_Y_KI_2PI = 5'd10;
    localparam logic [4:0] STEP_Y_KP     = 5'd11;
    localparam logic [4:0] STEP_Y_KP_2PI = 5'd12;
    localparam logic [4:0] STEP_Y_KD     = 5'd13;
    localparam logic [4:0] STEP_Y_KD_2PI = 5'd14;
    localparam logic [4:0] STEP_R_CFN    = 5'd15;
    localparam logic [4:0] STEP_R_SFE    = 5'd16;
    localparam logic [4:0] STEP_R_CFE    = 5'd17;
    localparam logic [4:0] STEP_R_SFN    = 5'd18;
    localparam logic [4:0] STEP_LAST     = STEP_R_SFN;

    // register indexes
    localparam logic [2:0] REG_POS_KP  = 3'd0;
    localparam logic [2:0] REG_POS_KI  = 3'd1;
    localparam logic [2:0] REG_POS_KD  = 3'd2;
    localparam logic [2:0] REG_YAW_KP  = 3'd3;
    localparam logic [2:0] REG_YAW_KI  = 3'd4;
    localparam logic [2:0] REG_YAW_KD  = 3'd5;
    localparam logic [2:0] REG_POS_DB  = 3'd6;
    localparam logic [2:0] REG_YAW_DB  = 3'd7;

    localparam logic signed [15:0] INTEG_MAX = 16'(INTEG_LIMIT);
    localparam logic signed [15:0] CMD_MAX   = 16'(FULL_Q14);

    // configuration
    logic [23:0] pos_kp_reg, pos_ki_reg, pos_kd_reg;
    logic [23:0] yaw_kp_reg, yaw_ki_reg, yaw_kd_reg;
    logic [15:0] pos_db_reg;
    logic [14:0] yaw_db_reg;

    // loop state
    logic signed [31:0] tgt_n_reg, tgt_e_reg;
    logic [15:0]        tgt_h_reg;
    logic signed [15:0] integ_n_reg, integ_e_reg, integ_y_reg;
    logic signed [31:0] last_n_reg, last_e_reg;
    logic signed [15:0] last_y_reg;
    logic               held_reg;

    // captured beat
    logic [1:0]         kind_reg;
    logic signed [31:0] pn_reg, pe_reg;
    logic [15:0]        hdg_reg;
    logic               pvalid_reg;

    // working values of an update
    logic signed [31:0] en_reg, ee_reg;
    logic signed [15:0] ey_reg;
    logic [15:0]        mn_reg, me_reg;
    logic               big_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic [32:0]        dbsq_reg, sq_reg;
    logic signed [PROD_W-1:0] facc_reg, racc_reg;
    logic signed [31:0] fn_reg, fe_reg;
    logic signed [15:0] fwd_res_reg, lat_res_reg, yaw_res_reg;

    logic [2:0] state_reg, state_next;
    logic [4:0] step_reg;

    // output register
    logic        m_valid_reg;
    logic [55:0] m_data_reg;

    // multiplier interface
    logic                      mul_start, mul_done;
    logic signed [PROD_W-1:0]  mul_a, mul_prod;
    logic signed [MUL_B_W-1:0] mul_b;

    dpp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign mul_start = (state_reg == ST_ISSUE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // error forming for the prep cycle
    logic signed [32:0] dn_raw, de_raw;
    logic signed [31:0] en_c, ee_c;
    logic [31:0]        mag_n, mag_e;
    logic signed [15:0] ey_raw;
    logic signed [16:0] ey_ext, mag_y;
    logic [TRIG_IDX_W-1:0] sin_idx, cos_idx;

    always_comb begin
        dn_raw  = 33'(tgt_n_reg) - 33'(pn_reg);
        de_raw  = 33'(tgt_e_reg) - 33'(pe_reg);
        en_c    = clamp_s32(PROD_W'(dn_raw));
        ee_c    = clamp_s32(PROD_W'(de_raw));
        mag_n   = en_c[31] ? 32'(-33'(en_c)) : 32'(en_c);
        mag_e   = ee_c[31] ? 32'(-33'(ee_c)) : 32'(ee_c);
        ey_raw  = signed'(tgt_h_reg - hdg_reg);
        ey_ext  = 17'(ey_raw);
        mag_y   = ey_raw[15] ? -ey_ext : ey_ext;
        sin_idx = hdg_reg[15 -: TRIG_IDX_W];
        cos_idx = sin_idx + TRIG_IDX_W'(TRIG_DEPTH / 4);
    end

    // rounded forms of the product
    logic signed [PROD_W-1:0] r10, r34, fwd_sum, lat_sum;
    logic signed [PROD_W-1:0] integ_n_sum, integ_e_sum, integ_y_sum;
    logic signed [32:0]       dif_n, dif_e;
    logic signed [16:0]       dif_y;
    logic [33:0]              sq_tot;

    always_comb begin
        r10         = rnd_shift(mul_prod, 10);
        r34         = rnd_shift(mul_prod, 34);
        fwd_sum     = rnd_shift(racc_reg + mul_prod, 14);
        lat_sum     = rnd_shift(racc_reg - mul_prod, 14);
        integ_n_sum = PROD_W'(integ_n_reg) + r10;
        integ_e_sum = PROD_W'(integ_e_reg) + r10;
        integ_y_sum = PROD_W'(integ_y_reg) + r34;
        dif_n       = 33'(en_reg) - 33'(last_n_reg);
        dif_e       = 33'(ee_reg) - 33'(last_e_reg);
        dif_y       = 17'(ey_reg) - 17'(last_y_reg);
        sq_tot      = {1'b0, sq_reg} + {1'b0, mul_prod[32:0]};
    end

    // select operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_DB_SQ: begin
                mul_a = PROD_W'(pos_db_reg);
                mul_b = MUL_B_W'(pos_db_reg);
            end
            STEP_N_SQ: begin
                mul_a = PROD_W'(mn_reg);
                mul_b = MUL_B_W'(mn_reg);
            end
            STEP_E_SQ: begin
                mul_a = PROD_W'(me_reg);
                mul_b = MUL_B_W'(me_reg);
            end
            STEP_N_KI: begin
                mul_a = PROD_W'(en_reg);
                mul_b = MUL_B_W'(pos_ki_reg);
            end
            STEP_N_KP: begin
                mul_a = PROD_W'(en_reg);
                mul_b = MUL_B_W'(pos_kp_reg);
            end
            STEP_N_KD: begin
                mul_a = PROD_W'(dif_n);
                mul_b = MUL_B_W'(pos_kd_reg);
            end
            STEP_E_KI: begin
                mul_a = PROD_W'(ee_reg);
                mul_b = MUL_B_W'(pos_ki_reg);
            end
            STEP_E_KP: begin
                mul_a = PROD_W'(ee_reg);
                mul_b = MUL_B_W'(pos_kp_reg);
            end
            STEP_E_KD: begin
                mul_a = PROD_W'(dif_e);
                mul_b = MUL_B_W'(pos_kd_reg);
            end
            STEP_Y_KI: begin
                mul_a = PROD_W'(ey_reg);
                mul_b = MUL_B_W'(yaw_ki_reg);
            end
            STEP_Y_KP: begin
                mul_a = PROD_W'(ey_reg);
                mul_b = MUL_B_W'(yaw_kp_reg);
            end
            STEP_Y_KD: begin
                mul_a = PROD_W'(dif_y);
                mul_b = MUL_B_W'(yaw_kd_reg);
            end
            STEP_Y_KI_2PI, STEP_Y_KP_2PI, STEP_Y_KD_2PI: begin
                mul_a = mul_prod;
                mul_b = MUL_B_W'(TWO_PI_Q16);
            end
            STEP_R_CFN: begin
                mul_a = PROD_W'(fn_reg);
                mul_b = MUL_B_W'(cos_reg);
            end
            STEP_R_SFE: begin
                mul_a = PROD_W'(fe_reg);
                mul_b = MUL_B_W'(sin_reg);
            end
            STEP_R_CFE: begin
                mul_a = PROD_W'(fe_reg);
                mul_b = MUL_B_W'(cos_reg);
            end
            STEP_R_SFN: begin
                mul_a = PROD_W'(fn_reg);
                mul_b = MUL_B_W'(sin_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // controller next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (kind_reg == KIND_UPDATE && held_reg && pvalid_reg) state_next = ST_PREP;
                else state_next = ST_OUT;
            end
            ST_PREP:   state_next = ST_ISSUE;
            ST_ISSUE:  state_next = ST_WAIT;
            ST_WAIT:   if (mul_done) state_next = ST_WB;
            ST_WB:     state_next = (step_reg == STEP_LAST) ? ST_OUT : ST_ISSUE;
            ST_OUT:    if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            pos_kp_reg  <= 24'd13107;
            pos_ki_reg  <= 24'd66;
            pos_kd_reg  <= 24'd0;
            yaw_kp_reg  <= 24'd131072;
            yaw_ki_reg  <= 24'd131;
            yaw_kd_reg  <= 24'd0;
            pos_db_reg  <= 16'd384;
            yaw_db_reg  <= 15'd910;
            tgt_n_reg   <= '0;
            tgt_e_reg   <= '0;
            tgt_h_reg   <= '0;
            integ_n_reg <= '0;
            integ_e_reg <= '0;
            integ_y_reg <= '0;
            last_n_reg  <= '0;
            last_e_reg  <= '0;
            last_y_reg  <= '0;
            held_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // register writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_POS_KP: pos_kp_reg <= cfg_data;
                    REG_POS_KI: pos_ki_reg <= cfg_data;
                    REG_POS_KD: pos_kd_reg <= cfg_data;
                    REG_YAW_KP: yaw_kp_reg <= cfg_data;
                    REG_YAW_KI: yaw_ki_reg <= cfg_data;
                    REG_YAW_KD: yaw_kd_reg <= cfg_data;
                    REG_POS_DB: pos_db_reg <= cfg_data[15:0];
                    REG_YAW_DB: yaw_db_reg <= cfg_data[14:0];
                    default:    pos_kp_reg <= pos_kp_reg;
                endcase
            end

            // engage and release
            if (state_reg == ST_DECIDE) begin
                step_reg <= '0;
                if (kind_reg == KIND_ENGAGE && pvalid_reg) begin
                    tgt_n_reg   <= pn_reg;
                    tgt_e_reg   <= pe_reg;
                    tgt_h_reg   <= hdg_reg;
                    integ_n_reg <= '0;
                    integ_e_reg <= '0;
                    integ_y_reg <= '0;
                    last_n_reg  <= '0;
                    last_e_reg  <= '0;
                    last_y_reg  <= '0;
                    held_reg    <= 1'b1;
                end else if (kind_reg == KIND_RELEASE) begin
                    held_reg <= 1'b0;
                end
            end

            // heading deadband drops the yaw integrator
            if (state_reg == ST_PREP && $unsigned(mag_y) < {2'b00, yaw_db_reg}) begin
                integ_y_reg <= '0;
            end

            // write back loop state per step
            if (state_reg == ST_WB) begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    STEP_E_SQ: begin
                        if (!big_reg && sq_tot < {1'b0, dbsq_reg}) begin
                            integ_n_reg <= '0;
                            integ_e_reg <= '0;
                        end
                    end
                    STEP_N_KI:     integ_n_reg <= clamp_lim(integ_n_sum, INTEG_LIMIT);
                    STEP_N_KD:     last_n_reg  <= en_reg;
                    STEP_E_KI:     integ_e_reg <= clamp_lim(integ_e_sum, INTEG_LIMIT);
                    STEP_E_KD:     last_e_reg  <= ee_reg;
                    STEP_Y_KI_2PI: integ_y_reg <= clamp_lim(integ_y_sum, INTEG_LIMIT);
                    STEP_Y_KD_2PI: last_y_reg  <= ey_reg;
                    default: ;
                endcase
            end

            // hold the result until the beat is taken
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg   <= s_tuser;
            pn_reg     <= s_tdata[31:0];
            pe_reg     <= s_tdata[63:32];
            hdg_reg    <= s_tdata[79:64];
            pvalid_reg <= s_tdata[80];
        end

        if (state_reg == ST_DECIDE) begin
            fwd_res_reg <= '0;
            lat_res_reg <= '0;
            yaw_res_reg <= '0;
        end

        // form the errors and fetch sine and cosine
        if (state_reg == ST_PREP) begin
            en_reg  <= en_c;
            ee_reg  <= ee_c;
            mn_reg  <= mag_n[15:0];
            me_reg  <= mag_e[15:0];
            big_reg <= (|mag_n[31:16]) | (|mag_e[31:16]);
            ey_reg  <= ($unsigned(mag_y) < {2'b00, yaw_db_reg}) ? 16'sd0 : ey_raw;
            sin_reg <= TRIG_TAB[sin_idx];
            cos_reg <= TRIG_TAB[cos_idx];
        end

        if (state_reg == ST_WB) begin
            case (step_reg)
                STEP_DB_SQ: dbsq_reg <= mul_prod[32:0];
                STEP_N_SQ:  sq_reg   <= mul_prod[32:0];
                STEP_E_SQ: begin
                    if (!big_reg && sq_tot < {1'b0, dbsq_reg}) begin
                        en_reg <= '0;
                        ee_reg <= '0;
                    end
                end
                STEP_N_KI, STEP_E_KI: begin
                    facc_reg <= PROD_W'(clamp_lim(
                        (step_reg == STEP_N_KI) ? integ_n_sum : integ_e_sum, INTEG_LIMIT));
                end
                STEP_N_KP, STEP_E_KP: facc_reg <= facc_reg + r10;
                STEP_N_KD:     fn_reg   <= clamp_s32(facc_reg + r10);
                STEP_E_KD:     fe_reg   <= clamp_s32(facc_reg + r10);
                STEP_Y_KI_2PI: facc_reg <= PROD_W'(clamp_lim(integ_y_sum, INTEG_LIMIT));
                STEP_Y_KP_2PI: facc_reg <= facc_reg + r34;
                STEP_Y_KD_2PI: yaw_res_reg <= clamp_lim(facc_reg + r34, FULL_Q14);
                STEP_R_CFN, STEP_R_CFE: racc_reg <= mul_prod;
                STEP_R_SFE:    fwd_res_reg <= clamp_lim(fwd_sum, FULL_Q14);
                STEP_R_SFN:    lat_res_reg <= clamp_lim(lat_sum, FULL_Q14);
                default:       racc_reg    <= racc_reg;
            endcase
        end

        // load the output beat
        if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {7'b0, held_reg, yaw_res_reg, lat_res_reg, fwd_res_reg};
        end
    end

    // multiplier finishes only while the controller waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier done outside wait");

    // a taken input beat always moves to the decision cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_DECIDE)
        else $error("input beat not followed by decision");

    // integrators stay within their limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        integ_n_reg <= INTEG_MAX && integ_n_reg >= -INTEG_MAX &&
        integ_e_reg <= INTEG_MAX && integ_e_reg >= -INTEG_MAX &&
        integ_y_reg <= INTEG_MAX && integ_y_reg >= -INTEG_MAX)
        else $error("integrator out of range");

    // forward and yaw commands on the output stay within full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (signed'(m_data_reg[15:0]) <= CMD_MAX &&
                         signed'(m_data_reg[15:0]) >= -CMD_MAX &&
                         signed'(m_data_reg[47:32]) <= CMD_MAX &&
                         signed'(m_data_reg[47:32]) >= -CMD_MAX))
        else $error("command beyond full scale");

endmodule

[test/dynamic_positioning_pid_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for dynamic_positioning_pid: directed and randomized engage,
// update and release beats against a cycle-free model of the three PID loops.
// Depends on dpp_pkg (item kinds and limits) and the dynamic_positioning_pid RTL.
module dynamic_positioning_pid_tb;
    import dpp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int N_RANDOM       = 1680;

    typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_op_t;
    typedef enum logic [2:0] {
        REG_POS_KP, REG_POS_KI, REG_POS_KD, REG_YAW_KP,
        REG_YAW_KI, REG_YAW_KD, REG_POS_DB, REG_YAW_DB
    } reg_idx_t;

    typedef struct {
        job_op_t            op;
        logic [1:0]         kind;
        logic signed [31:0] pn;
        logic signed [31:0] pe;
        logic [15:0]        hdg;
        logic               pv;
        logic [2:0]         idx;
        logic [23:0]        val;
        int                 s_idle;
        int                 m_idle;
    } job_t;

    typedef struct {
        logic signed [15:0] fwd;
        logic signed [15:0] lat;
        logic signed [15:0] yaw;
        logic               hold;
    } cmd_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;  // pos_north, pos_east, heading, pos_valid, zero fill
    logic [1:0]  s_tuser   = '0;  // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;         // forward_cmd, lateral_cmd, yaw_cmd, holding, zero fill
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    dynamic_positioning_pid dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    job_t   jobs[$];
    cmd_t   cmd_q[$];
    job_t   in_flight;
    int     m_idle_pct = 0;
    int     errors     = 0;
    int     quiet_cycles = 0;

    // model state and registers
    longint gain[8];
    longint tgt_n, tgt_e, tgt_h;
    longint int_n, int_e, int_y;
    longint prev_n, prev_e, prev_y;
    bit     held;

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint rnd(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sine_q14(int unsigned p);
        int unsigned quad, z, z2, t;
        longint s;
        p    = p & 16'hFFFF;
        quad = p >> 14;
        z    = p & 16'h3FFF;
        if (quad[0]) z = 16384 - z;
        z2 = (z * z) >> 14;
        t  = (1160 * z2) >> 14;
        t  = 10512 - t;
        t  = (t * z2) >> 14;
        t  = 25736 - t;
        s  = (t * z) >> 14;
        return quad[1] ? -s : s;
    endfunction

    function automatic longint heading_term(longint err, longint g);
        return rnd(err * g * 411775, 34);
    endfunction

    function automatic void load_defaults();
        gain = '{13107, 66, 0, 131072, 131, 0, 384, 910};
        tgt_n = 0; tgt_e = 0; tgt_h = 0;
        int_n = 0; int_e = 0; int_y = 0;
        prev_n = 0; prev_e = 0; prev_y = 0;
        held = 0;
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [23:0] val);
        case (reg_idx_t'(idx))
            REG_POS_DB: gain[idx] = val & 24'hFFFF;
            REG_YAW_DB: gain[idx] = val & 24'h7FFF;
            default:    gain[idx] = val;
        endcase
    endfunction

    // compute the command beat for one accepted item and advance model state
    function automatic cmd_t station_cmd(job_t j);
        cmd_t   c;
        longint en, ee, fn, fe, ey, fwd, lat, myaw, sn, cs, idx;
        longint unsigned mn, me;
        fwd = 0; lat = 0; myaw = 0;
        if (j.kind == KIND_ENGAGE) begin
            if (j.pv) begin
                tgt_n = j.pn; tgt_e = j.pe; tgt_h = j.hdg;
                int_n = 0; int_e = 0; int_y = 0;
                prev_n = 0; prev_e = 0; prev_y = 0;
                held = 1;
            end
        end else if (j.kind == KIND_RELEASE) begin
            held = 0;
        end else if (j.kind == KIND_UPDATE && held && j.pv) begin
            en = clip(tgt_n - longint'(j.pn), -64'sh8000_0000, 64'sh7FFF_FFFF);
            ee = clip(tgt_e - longint'(j.pe), -64'sh8000_0000, 64'sh7FFF_FFFF);
            mn = en < 0 ? -en : en;
            me = ee < 0 ? -ee : ee;
            if (mn * mn + me * me < longint'(gain[REG_POS_DB] * gain[REG_POS_DB])) begin
                en = 0; ee = 0; int_n = 0; int_e = 0;
            end
            int_n = clip(int_n + rnd(en * gain[REG_POS_KI], 10), -INTEG_LIMIT, INTEG_LIMIT);
            int_e = clip(int_e + rnd(ee * gain[REG_POS_KI], 10), -INTEG_LIMIT, INTEG_LIMIT);
            fn = rnd(en * gain[REG_POS_KP], 10) + int_n
               + rnd((en - prev_n) * gain[REG_POS_KD], 10);
            fe = rnd(ee * gain[REG_POS_KP], 10) + int_e
               + rnd((ee - prev_e) * gain[REG_POS_KD], 10);
            prev_n = en;
            prev_e = ee;
            fn = clip(fn, -64'sh8000_0000, 64'sh7FFF_FFFF);
            fe = clip(fe, -64'sh8000_0000, 64'sh7FFF_FFFF);

            // wrapped heading error; half a turn lands on the negative side
            ey = (tgt_h - longint'(j.hdg)) & 16'hFFFF;
            if (ey >= 32768) ey -= 65536;
            if ((ey < 0 ? -ey : ey) < gain[REG_YAW_DB]) begin
                ey = 0; int_y = 0;
            end
            int_y = clip(int_y + heading_term(ey, gain[REG_YAW_KI]), -INTEG_LIMIT, INTEG_LIMIT);
            myaw = heading_term(ey, gain[REG_YAW_KP]) + int_y
                 + heading_term(ey - prev_y, gain[REG_YAW_KD]);
            prev_y = ey;

            // rotate into body frame with the coarse sine table
            idx = j.hdg >> 8;
            sn  = sine_q14(int'(idx) * 256);
            cs  = sine_q14(int'((idx + 64) % 256) * 256);
            fwd = clip(rnd(cs * fn + sn * fe, 14), -FULL_Q14, FULL_Q14);
            lat = clip(rnd(cs * fe - sn * fn, 14), -FULL_Q14, FULL_Q14);
            myaw = clip(myaw, -FULL_Q14, FULL_Q14);
        end
        c.fwd  = fwd[15:0];
        c.lat  = lat[15:0];
        c.yaw  = myaw[15:0];
        c.hold = held;
        return c;
    endfunction

    // driver: take jobs in order, register writes only once all commands are back
    always @(posedge aclk) begin
        job_t j;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) cmd_q.push_back(station_cmd(in_flight));
            if (s_tvalid && !s_tready) begin
                cfg_wr_en <= 1'b0;
            end else if (jobs.size() == 0) begin
                s_tvalid  <= 1'b0;
                cfg_wr_en <= 1'b0;
            end else begin
                j = jobs[0];
                if (j.op != JOB_ITEM) begin
                    s_tvalid <= 1'b0;
                    if (cmd_q.size() == 0) begin
                        void'(jobs.pop_front());
                        cfg_wr_en <= (j.op == JOB_CFG);
                        cfg_index <= j.idx;
                        cfg_data  <= j.val;
                        if (j.op == JOB_CFG) write_reg(j.idx, j.val);
                    end else begin
                        cfg_wr_en <= 1'b0;
                    end
                end else begin
                    cfg_wr_en  <= 1'b0;
                    m_idle_pct  = j.m_idle;
                    if ($urandom_range(99) < j.s_idle) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid  <= 1'b1;
                        s_tdata   <= {7'b0, j.pv, j.hdg, j.pe, j.pn};
                        s_tuser   <= j.kind;
                        in_flight  = j;
                        void'(jobs.pop_front());
                    end
                end
            end
        end
    end

    task automatic field_check(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: random backpressure, compare each command beat with the oldest prediction
    always @(posedge aclk) begin
        cmd_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = cmd_q.pop_front();
                    field_check("forward_cmd", want.fwd, $signed(m_tdata[15:0]));
                    field_check("lateral_cmd", want.lat, $signed(m_tdata[31:16]));
                    field_check("yaw_cmd", want.yaw, $signed(m_tdata[47:32]));
                    field_check("holding", want.hold, m_tdata[48]);
                end
            end
            m_tready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dynamic_positioning_pid_tb failed");
            $finish;
        end
    end

    int s_idle_cur = 0;
    int m_idle_cur = 0;

    task automatic add_item(logic [1:0] kind, logic signed [31:0] pn, logic signed [31:0] pe,
                            logic [15:0] hdg, logic pv);
        job_t j;
        j = '{op: JOB_ITEM, kind: kind, pn: pn, pe: pe, hdg: hdg, pv: pv, idx: 0, val: 0,
              s_idle: s_idle_cur, m_idle: m_idle_cur};
        jobs.push_back(j);
    endtask

    task automatic add_ctrl(job_op_t op, logic [2:0] idx, logic [23:0] val);
        job_t j;
        j = '{op: op, kind: 0, pn: 0, pe: 0, hdg: 0, pv: 0, idx: idx, val: val,
              s_idle: 0, m_idle: 0};
        jobs.push_back(j);
    endtask

    function automatic logic [23:0] rand_gain();
        return 24'($urandom & ((32'd1 << $urandom_range(24)) - 1));
    endfunction

    function automatic logic signed [31:0] near(logic signed [31:0] base);
        return base + ($signed($urandom) >>> $urandom_range(31, 8));
    endfunction

    task automatic set_regs(int mode);
        for (int r = 0; r < 8; r++) begin
            logic [23:0] v;
            case (mode)
                0: v = (r == REG_YAW_DB) ? 24'd16384 : (r == REG_POS_DB) ? 24'hFFFF
                                                                        : 24'hFFFFFF;
                1: v = 0;
                default: begin
                    v = rand_gain();
                    if (r == REG_POS_DB) v = 24'($urandom_range(2000));
                    if (r == REG_YAW_DB) v = 24'($urandom_range(16384) >> $urandom_range(6));
                end
            endcase
            add_ctrl(JOB_CFG, r[2:0], v);
        end
    endtask

    // directed beats: extremes, every kind and each special case
    task automatic add_directed();
        add_item(KIND_UPDATE, 100, 100, 0, 1);                   // no target yet
        add_item(KIND_ENGAGE, 5, 5, 16'h1234, 0);                // refused engage
        add_item(2'd3, -1, -1, 16'hFFFF, 1);                     // unused kind
        add_item(KIND_ENGAGE, 0, 0, 0, 1);
        add_item(KIND_UPDATE, 0, 0, 0, 1);                       // inside deadband
        add_item(KIND_UPDATE, 1000, -700, 16'h0100, 1);
        add_item(KIND_UPDATE, -32'sh8000_0000, 32'sh7FFF_FFFF, 16'h8000, 1); // half turn
        add_item(KIND_UPDATE, 50, 50, 16'h4000, 0);              // invalid position
        add_item(KIND_UPDATE, -300, 200, 16'hC000, 1);
        add_item(KIND_RELEASE, 0, 0, 0, 1);
        add_item(KIND_UPDATE, 300, 300, 16'h2000, 1);            // released
        add_item(KIND_ENGAGE, -32'sh8000_0000, -32'sh8000_0000, 16'hFFFF, 1);
        add_item(KIND_UPDATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
        add_item(KIND_UPDATE, 32'sh7FFF_FFFF, -32'sh8000_0000, 16'h7FFF, 1);
        add_item(KIND_ENGAGE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000, 1);
        add_item(KIND_UPDATE, -32'sh8000_0000, -32'sh8000_0000, 0, 1);
        add_item(KIND_UPDATE, 32'sh7FFF_FF00, 32'sh7FFF_FFF0, 16'h8001, 1);
        add_item(KIND_UPDATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000, 1);
        add_item(2'd3, 0, 0, 0, 0);
        add_item(KIND_RELEASE, -1, -1, 16'hFFFF, 0);
    endtask

    initial begin
        int made;
        int mode;
        logic signed [31:0] tn, te;
        logic [15:0] th;
        load_defaults();
        add_directed();
        made = 0;
        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            s_idle_cur = (mode == 1 || mode == 3) ? ((mode == 1) ? 66 : 19) : 0;
            m_idle_cur = (mode == 2 || mode == 3) ? ((mode == 2) ? 66 : 19) : 0;
            if (ph > 0) set_regs(ph == 1 ? 2 : ph == 3 ? 0 : ph == 5 ? 1 : 2);
            while (made < (ph + 1) * N_RANDOM / 8) begin
                // engage, a run of updates near the target, sometimes a release
                tn = $urandom; te = $urandom; th = 16'($urandom);
                add_item(KIND_ENGAGE, tn, te, th, $urandom_range(9) != 0);
                made++;
                repeat ($urandom_range(25, 3)) begin
                    if ($urandom_range(9) == 0) begin
                        add_item(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom),
                                 1'($urandom_range(1)));
                    end else begin
                        add_item(KIND_UPDATE, near(tn), near(te),
                                 16'(th + ($signed($urandom) >>> $urandom_range(31, 16))),
                                 $urandom_range(19) != 0);
                    end
                    made++;
                end
                if ($urandom_range(3) == 0) begin
                    add_item(KIND_RELEASE, $urandom, $urandom, 16'($urandom),
                             1'($urandom_range(1)));
                    made++;
                end
                if (ph == 4 && made % 50 < 10) add_ctrl(JOB_DRAIN, 0, 0);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (jobs.size() != 0 || s_tvalid || cmd_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && cmd_q.size() == 0) begin
            $display("dynamic_positioning_pid_tb passed");
        end else begin
            $display("dynamic_positioning_pid_tb failed");
        end
        $finish;
    end

endmodule
